/* hw/rtl/dsrt_pkg.sv */
// ----------------------------------------------------------------------------
// dsrt_pkg: shared types and constants for the date-sorted record table
// Record layout, date key helper, operation and status codes, cell actions.
// ----------------------------------------------------------------------------
package dsrt_pkg;

  // field widths
  localparam int CODE_W   = 14;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int POSTAL_W = 17;
  // widest key: 16383*10000 + 15*100 + 31 fits in 28 bits
  localparam int KEY_W    = 28;

  localparam logic [KEY_W-1:0] YEAR_SCALE  = KEY_W'(10000);
  localparam logic [KEY_W-1:0] MONTH_SCALE = KEY_W'(100);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_SEARCH  = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_RANGE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_REJECT   = 2'd3
  } status_t;

  // per-cell update selection
  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CMP   = 2'd1,
    S_APPLY = 2'd2
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [POSTAL_W-1:0] postal;
  } rec_t;

  // request broadcast to every cell for the compare step
  typedef struct packed {
    op_t               op;
    logic              neg;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
  } cmp_req_t;

  function automatic logic [KEY_W-1:0] date_key(
    input logic [DAY_W-1:0]   d,
    input logic [MONTH_W-1:0] m,
    input logic [YEAR_W-1:0]  y
  );
    return KEY_W'(y) * YEAR_SCALE + KEY_W'(m) * MONTH_SCALE + KEY_W'(d);
  endfunction

endpackage

/* hw/rtl/date_sorted_record_table_core.sv */
// ----------------------------------------------------------------------------
// date_sorted_record_table_core: record table kept sorted by date, newest first
// Insert, search by code, extract by code and extract by date range.
// ----------------------------------------------------------------------------
// A request passes the accept cycle, which registers the request and its
// date keys, a compare cycle in which every cell of the chain compares its
// record, and an update cycle that picks the first hit and shifts the chain
// by one slot for an insert or removal. The result shows on the out_ ports
// with out_valid high for one cycle right after that; the receiver cannot
// stall, so it must take it then. busy is high for the compare and update
// cycles, and a new request may be started in the cycle the result is
// shown. The table is empty after reset and needs no clearing time.
module date_sorted_record_table_core
  import dsrt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic signed [14:0]  in_code,
  input  logic [4:0]          in_day,
  input  logic [3:0]          in_month,
  input  logic [13:0]         in_year,
  input  logic [4:0]          in_day_b,
  input  logic [3:0]          in_month_b,
  input  logic [13:0]         in_year_b,
  input  logic [16:0]         in_postal_code,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [13:0]         out_found_code,
  output logic [4:0]          out_found_day,
  output logic [3:0]          out_found_month,
  output logic [13:0]         out_found_year,
  output logic [16:0]         out_found_postal
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  cmp_req_t           req_r;
  rec_t               new_rec_r;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  rec_t               out_rec_r, out_rec_nxt;

  rec_t               cell_rec [ENTRIES];
  logic [KEY_W-1:0]   cell_key [ENTRIES];
  act_t               cell_act [ENTRIES];
  logic [ENTRIES-1:0] hit_vec, gt_vec, valid_vec;
  logic [ENTRIES-1:0] hit_m1, first_vec, below_vec;
  logic               found, full, ins_ok, do_apply;
  rec_t               picked;

  // request capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r.op         <= op_t'(in_opcode);
      req_r.neg        <= in_code[14];
      req_r.code       <= in_code[13:0];
      req_r.key_a      <= date_key(in_day, in_month, in_year);
      req_r.key_b      <= date_key(in_day_b, in_month_b, in_year_b);
      new_rec_r.code   <= in_code[13:0];
      new_rec_r.day    <= in_day;
      new_rec_r.month  <= in_month;
      new_rec_r.year   <= in_year;
      new_rec_r.postal <= in_postal_code;
    end
  end

  // cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign valid_vec[i] = count_r > CNT_W'(i);
    dsrt_cell u_cell (
      .clk       (clk),
      .valid     (valid_vec[i]),
      .req       (req_r),
      .act       (cell_act[i]),
      .new_rec   (new_rec_r),
      .new_key   (req_r.key_a),
      .left_rec  (cell_rec[(i == 0) ? 0 : i - 1]),
      .left_key  (cell_key[(i == 0) ? 0 : i - 1]),
      .right_rec (cell_rec[(i == ENTRIES - 1) ? i : i + 1]),
      .right_key (cell_key[(i == ENTRIES - 1) ? i : i + 1]),
      .rec       (cell_rec[i]),
      .key       (cell_key[i]),
      .hit       (hit_vec[i]),
      .gt        (gt_vec[i])
    );
  end

  // first hit isolation: lowest set bit, and the mask of slots ahead of it
  assign hit_m1    = hit_vec - ENTRIES'(1);
  assign first_vec = hit_vec & ~hit_m1;
  assign below_vec = ~hit_vec & hit_m1;
  assign found     = |hit_vec;
  assign full      = count_r == CNT_W'(ENTRIES);
  assign ins_ok    = (req_r.op == OP_INSERT) && !req_r.neg && !full;
  assign do_apply  = state_r == S_APPLY;

  // record of the first hit (zero when none)
  always_comb begin
    picked = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_vec[i]) picked = picked | cell_rec[i];
    end
  end

  // per-cell actions: insert shifts right from the slot, removal shifts left
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_act[i] = ACT_HOLD;
      if (do_apply && ins_ok && !gt_vec[i]) begin
        if (i == 0) cell_act[i] = ACT_LOAD;
        else if (gt_vec[(i == 0) ? 0 : i - 1]) cell_act[i] = ACT_LOAD;
        else cell_act[i] = ACT_LEFT;
      end else if (do_apply && found && (req_r.op != OP_SEARCH) && !below_vec[i] &&
                   (i != ENTRIES - 1)) begin
        cell_act[i] = ACT_RIGHT;
      end
    end
  end

  // control and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rec_nxt   = picked;
        if (req_r.op == OP_INSERT) begin
          if (req_r.neg) out_status_nxt = STAT_REJECT;
          else if (full) out_status_nxt = STAT_FULL;
          else begin
            out_status_nxt = STAT_OK;
            count_nxt      = count_r + CNT_W'(1);
          end
        end else if (found) begin
          out_status_nxt = STAT_OK;
          if (req_r.op != OP_SEARCH) count_nxt = count_r - CNT_W'(1);
        end else begin
          out_status_nxt = STAT_NOTFOUND;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_code   = out_rec_r.code;
  assign out_found_day    = out_rec_r.day;
  assign out_found_month  = out_rec_r.month;
  assign out_found_year   = out_rec_r.year;
  assign out_found_postal = out_rec_r.postal;

endmodule

/* hw/rtl/dsrt_cell.sv */
// ----------------------------------------------------------------------------
// dsrt_cell: one slot of the sorted record chain
// Holds a record and its date key, compares them against the broadcast
// request and loads new data, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module dsrt_cell
  import dsrt_pkg::*;
(
  input  logic             clk,
  input  logic             valid,
  input  cmp_req_t         req,
  input  act_t             act,
  input  rec_t             new_rec,
  input  logic [KEY_W-1:0] new_key,
  input  rec_t             left_rec,
  input  logic [KEY_W-1:0] left_key,
  input  rec_t             right_rec,
  input  logic [KEY_W-1:0] right_key,
  output rec_t             rec,
  output logic [KEY_W-1:0] key,
  output logic             hit,
  output logic             gt
);

  rec_t             rec_r, rec_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             hit_r, hit_nxt;
  logic             gt_r, gt_nxt;
  logic             in_range;

  // compare against the request; range bounds may come in either order
  always_comb begin
    in_range = ((key_r >= req.key_a) && (key_r <= req.key_b)) ||
               ((key_r >= req.key_b) && (key_r <= req.key_a));
    gt_nxt   = valid && (key_r > req.key_a);
    case (req.op) inside
      OP_SEARCH, OP_EXTRACT: hit_nxt = valid && !req.neg && (rec_r.code == req.code);
      OP_RANGE:              hit_nxt = valid && in_range;
      default:               hit_nxt = 1'b0;
    endcase
  end

  // slot update
  always_comb begin
    case (act)
      ACT_LOAD: begin
        rec_nxt = new_rec;
        key_nxt = new_key;
      end
      ACT_LEFT: begin
        rec_nxt = left_rec;
        key_nxt = left_key;
      end
      ACT_RIGHT: begin
        rec_nxt = right_rec;
        key_nxt = right_key;
      end
      default: begin
        rec_nxt = rec_r;
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    key_r <= key_nxt;
    hit_r <= hit_nxt;
    gt_r  <= gt_nxt;
  end

  assign rec = rec_r;
  assign key = key_r;
  assign hit = hit_r;
  assign gt  = gt_r;

endmodule
